// ===== rtl/pcmd_pkg.sv =====
// Package for the polar cell minimum depth table: payload structs, cell word layout,
// item kind codes and sizing constants. No dependencies.
package pcmd_pkg;

  localparam int CELLS_DEFAULT = 512;
  localparam int CELL_W        = 9;
  localparam int DEPTH_W       = 32;
  localparam int CELL_CMP_W    = 13;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_RESET  = 2'd2,
    KIND_BORDER = 2'd3
  } kind_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [CELL_W-1:0]   cell_req;
    logic [DEPTH_W-1:0]  pt_dist_sq;
    logic                clearing;
  } in_item_t;

  typedef struct packed {
    logic                not_empty;
    logic [DEPTH_W-1:0]  min_depth_sq;
  } out_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]  nearest_sq;
    logic                was_cleared;
    logic                occupied;
    logic                is_border;
  } cell_word_t;

  typedef struct packed {
    logic       we;
    cell_word_t word;
    logic       rd;
    out_item_t  res;
  } upd_t;

  localparam int WORD_W = $bits(cell_word_t);

  localparam cell_word_t CLEAR_WORD = '{
    nearest_sq:  {DEPTH_W{1'b1}},
    was_cleared: 1'b0,
    occupied:    1'b0,
    is_border:   1'b0
  };

endpackage

// ===== rtl/pcmd_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module pcmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pcmd_update.sv =====
// Cell update logic: computes the new cell word and the read result for one transaction.
// Depends on pcmd_pkg.
module pcmd_update (
  input  pcmd_pkg::in_item_t             item,
  input  logic                           cell_ok,
  input  pcmd_pkg::cell_word_t           cur,
  input  logic [pcmd_pkg::DEPTH_W-1:0]   limit_sq,
  output pcmd_pkg::upd_t                 upd
);

  pcmd_pkg::cell_word_t nw;
  logic                 d_lt_n;
  logic                 d_gt_n;
  logic                 d_lt_max;

  assign d_lt_n   = item.pt_dist_sq < cur.nearest_sq;
  assign d_gt_n   = item.pt_dist_sq > cur.nearest_sq;
  assign d_lt_max = item.pt_dist_sq < limit_sq;

  always_comb begin
    nw = cur;
    case (item.kind)
      pcmd_pkg::KIND_INSERT: begin
        if (item.clearing && !cur.is_border) begin
          if (!d_lt_max) begin
            nw.nearest_sq = limit_sq;
            nw.occupied   = 1'b0;
          end else if (!cur.occupied) begin
            nw.occupied   = 1'b1;
            nw.nearest_sq = item.pt_dist_sq;
          end else if (d_lt_n) begin
            nw.nearest_sq = item.pt_dist_sq;
          end
          nw.was_cleared = 1'b1;
        end else if (cur.was_cleared) begin
          if (d_gt_n) begin
            nw.occupied = 1'b1;
          end
        end else begin
          if (d_lt_n) begin
            nw.nearest_sq = item.pt_dist_sq;
          end
          if (d_lt_max) begin
            nw.occupied = 1'b1;
          end
        end
      end
      pcmd_pkg::KIND_RESET: begin
        nw.nearest_sq  = limit_sq;
        nw.occupied    = 1'b0;
        nw.was_cleared = 1'b0;
      end
      pcmd_pkg::KIND_BORDER: begin
        nw.is_border = 1'b1;
      end
      default: begin
        nw = cur;
      end
    endcase
  end

  always_comb begin
    upd.we   = cell_ok && (item.kind != pcmd_pkg::KIND_READ);
    upd.word = nw;
    upd.rd   = item.kind == pcmd_pkg::KIND_READ;
    if (cell_ok && cur.occupied) begin
      upd.res.not_empty    = 1'b1;
      upd.res.min_depth_sq = cur.nearest_sq;
    end else begin
      upd.res.not_empty    = 1'b0;
      upd.res.min_depth_sq = limit_sq;
    end
  end

endmodule

// ===== rtl/polar_cell_min_depth_table_unit.sv =====
// Top level of the polar cell minimum depth table: cell memory, read-modify-write stage,
// forwarding register, configuration register and post-reset clearing pass.
// Depends on pcmd_pkg, pcmd_ram and pcmd_update.
//
// Usage: a transaction is taken on a rising edge where start is high and busy is low.
// Its payload names the kind (insert, read, reset cell, mark border), the cell, the
// squared depth and the clearing flag. Only a read gives a result: out_strobe is high
// for exactly one cycle, driven from a result register behind the read-modify-write
// stage, with not_empty and min_depth_sq. The receiver cannot stall, so every result
// must be taken when shown.
// Throughput is one transaction per cycle while busy is low. The cell memory is read on
// the accepting edge and written back on the next edge; a transaction to the cell
// written just before it takes the data from a forwarding register.
// After reset, busy stays high while a clearing pass writes every cell to empty, one
// cell a cycle. The limit register resets to all ones and is written through cfg_we
// and cfg_wdata whenever cfg_we is high, including during the clearing pass; writing
// it leaves the cells untouched.
module polar_cell_min_depth_table_unit #(
  parameter int CELLS = pcmd_pkg::CELLS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pcmd_pkg::in_item_t            in_item,
  output logic                          out_strobe,
  output pcmd_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [pcmd_pkg::DEPTH_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(CELLS);

  pcmd_pkg::state_t     state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [pcmd_pkg::DEPTH_W-1:0] max_r;

  logic                 accept;
  logic [pcmd_pkg::CELL_CMP_W-1:0] in_cell_ext;
  logic [AW-1:0]        in_addr;
  logic                 in_ok;

  logic                 s1_valid_r;
  pcmd_pkg::in_item_t   s1_item_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 s1_ok_r;

  logic                 fwd_valid_r;
  logic [AW-1:0]        fwd_addr_r;
  pcmd_pkg::cell_word_t fwd_data_r;

  logic [pcmd_pkg::WORD_W-1:0] ram_rdata;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  pcmd_pkg::cell_word_t ram_wdata;
  pcmd_pkg::cell_word_t cur;
  pcmd_pkg::upd_t       upd;
  logic                 item_we;

  logic                 out_strobe_r;
  pcmd_pkg::out_item_t  out_item_r;

  assign busy        = state_r == pcmd_pkg::ST_CLEAR;
  assign accept      = start && !busy;
  assign in_cell_ext = pcmd_pkg::CELL_CMP_W'(in_item.cell_req);
  assign in_addr     = in_cell_ext[AW-1:0];
  assign in_ok       = in_cell_ext < pcmd_pkg::CELL_CMP_W'(CELLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pcmd_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      pcmd_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(CELLS - 1)) begin
          state_nxt    = pcmd_pkg::ST_RUN;
          clr_addr_nxt = '0;
        end
      end
      pcmd_pkg::ST_RUN: begin
        state_nxt = pcmd_pkg::ST_RUN;
      end
      default: begin
        state_nxt = pcmd_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= {pcmd_pkg::DEPTH_W{1'b1}};
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_item_r <= in_item;
      s1_addr_r <= in_addr;
      s1_ok_r   <= in_ok;
    end
  end

  pcmd_ram #(
    .WIDTH (pcmd_pkg::WORD_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      cur = fwd_data_r;
    end else begin
      cur = pcmd_pkg::cell_word_t'(ram_rdata);
    end
  end

  pcmd_update u_update (
    .item     (s1_item_r),
    .cell_ok  (s1_ok_r),
    .cur      (cur),
    .limit_sq (max_r),
    .upd      (upd)
  );

  assign item_we = s1_valid_r && upd.we;

  always_comb begin
    if (busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = pcmd_pkg::CLEAR_WORD;
    end else begin
      ram_we    = item_we;
      ram_waddr = s1_addr_r;
      ram_wdata = upd.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= item_we;
    end
    if (item_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= upd.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r && upd.rd;
    end
    if (s1_valid_r && upd.rd) begin
      out_item_r <= upd.res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_strobe_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(s1_valid_r && (s1_item_r.kind == pcmd_pkg::KIND_READ)))
    else $error("result strobe without a read transaction");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcmd_pkg::ST_CLEAR) |-> !s1_valid_r && !fwd_valid_r)
    else $error("transaction in flight during clearing pass");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(clr_addr_r) == AW'(CELLS - 1))
    else $error("clearing pass ended before the last cell");

endmodule

// ===== dv/tb_polar_cell_min_depth_table_unit.sv =====
// Self-checking testbench for polar_cell_min_depth_table_unit: directed and random
// transactions, a cell table predictor and an in-order result scoreboard.
// Depends on pcmd_pkg and the RTL of the unit.
module tb_polar_cell_min_depth_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pcmd_pkg::*;

  localparam int NCELLS      = CELLS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 4;
  localparam int IN_W        = $bits(in_item_t);

  class min_depth_scoreboard;
    logic [DEPTH_W-1:0] nearest [NCELLS];
    bit                 cleared [NCELLS];
    bit                 occupied [NCELLS];
    bit                 border [NCELLS];
    logic [DEPTH_W-1:0] limit;
    out_item_t          pending_reads [$];
    int                 errors;

    function new();
      limit  = '1;
      errors = 0;
      foreach (nearest[i]) begin
        nearest[i]  = '1;
        cleared[i]  = 0;
        occupied[i] = 0;
        border[i]   = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return pending_reads.size();
    endfunction

    function void empty_cell(int c);
      nearest[c]  = limit;
      occupied[c] = 0;
      cleared[c]  = 0;
    endfunction

    function void apply_transaction(in_item_t it);
      out_item_t          r;
      int                 c;
      logic [DEPTH_W-1:0] d;
      c = int'(it.cell_req);
      d = it.pt_dist_sq;
      case (it.kind)
        KIND_READ: begin
          r.not_empty    = occupied[c];
          r.min_depth_sq = occupied[c] ? nearest[c] : limit;
          pending_reads.insert(pending_reads.size(), r);
        end
        KIND_INSERT: begin
          if (it.clearing && !border[c]) begin
            if (d >= limit) begin
              empty_cell(c);
            end else if (!occupied[c]) begin
              occupied[c] = 1;
              nearest[c]  = d;
            end else if (d < nearest[c]) begin
              nearest[c] = d;
            end
            cleared[c] = 1;
          end else if (cleared[c]) begin
            if (d > nearest[c]) occupied[c] = 1;
          end else begin
            if (d < nearest[c]) nearest[c] = d;
            if (d < limit) occupied[c] = 1;
          end
        end
        KIND_RESET: empty_cell(c);
        default: border[c] = 1;
      endcase
    endfunction

    task check_cell_report(out_item_t got);
      out_item_t want;
      if (pending_reads.size() == 0) begin
        report($sformatf("result %0b/%h with no read outstanding",
                         got.not_empty, got.min_depth_sq));
      end else begin
        want = pending_reads.pop_front();
        if (got.not_empty !== want.not_empty)
          report($sformatf("not_empty got %b expected %b", got.not_empty, want.not_empty));
        if (got.min_depth_sq !== want.min_depth_sq)
          report($sformatf("min_depth_sq got %h expected %h",
                           got.min_depth_sq, want.min_depth_sq));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_item;
  logic               out_strobe;
  out_item_t          out_item;
  logic               cfg_we;
  logic [DEPTH_W-1:0] cfg_wdata;
  int                 cycles = 0;

  min_depth_scoreboard sb = new();

  polar_cell_min_depth_table_unit #(.CELLS(NCELLS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Results are checked before the transaction taken on the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_cell_report(out_item);
      if (start && !busy) sb.apply_transaction(in_item);
    end
  end

  function automatic in_item_t mk(kind_t k, int c, logic [DEPTH_W-1:0] d, int clr);
    in_item_t it;
    it.kind       = k;
    it.cell_req   = c[CELL_W-1:0];
    it.pt_dist_sq = d;
    it.clearing   = clr[0];
    return it;
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    logic [DEPTH_W-1:0] lim;
    lim = sb.limit;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return lim;
      3: return lim - 1;
      4: return lim + 1;
      5: return $urandom;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic in_item_t random_item();
    int    r;
    int    c;
    kind_t k;
    r = $urandom_range(0, 99);
    c = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 31) : $urandom_range(0, NCELLS - 1);
    if (r < 55) k = KIND_INSERT;
    else if (r < 85) k = KIND_READ;
    else if (r < 97) k = KIND_RESET;
    else begin
      k = KIND_BORDER;
      c = $urandom_range(0, NCELLS - 1);
    end
    return mk(k, c, pick_depth(), $urandom_range(0, 1));
  endfunction

  task automatic drive_item(in_item_t it, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= in_item_t'(IN_W'({$urandom, $urandom}));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(logic [DEPTH_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.limit = v;
  endtask

  task automatic random_phase(int n, bit idling);
    int gap;
    repeat (n) begin
      gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
      drive_item(random_item(), gap);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);

    drive_item(mk(KIND_READ, 0, '0, 0), 0);
    drive_item(mk(KIND_INSERT, 0, '0, 0), 0);
    drive_item(mk(KIND_READ, 0, '1, 1), 0);
    drive_item(mk(KIND_INSERT, NCELLS - 1, '1, 0), 0);
    drive_item(mk(KIND_READ, NCELLS - 1, '0, 0), 0);
    drive_item(mk(KIND_INSERT, 5, 32'd100, 1), 0);
    drive_item(mk(KIND_INSERT, 5, 32'd200, 0), 0);
    drive_item(mk(KIND_READ, 5, '0, 0), 0);
    drive_item(mk(KIND_INSERT, 5, '1, 1), 0);
    drive_item(mk(KIND_READ, 5, '0, 0), 0);
    drive_item(mk(KIND_BORDER, 7, '0, 0), 0);
    drive_item(mk(KIND_INSERT, 7, 32'd50, 1), 0);
    drive_item(mk(KIND_READ, 7, '0, 0), 0);
    drive_item(mk(KIND_RESET, 7, '0, 0), 0);
    drive_item(mk(KIND_READ, 7, '0, 0), 0);
    drive_item(mk(KIND_INSERT, 1, 32'd30, 0), 0);
    drive_item(mk(KIND_INSERT, 1, 32'd20, 0), 0);
    drive_item(mk(KIND_READ, 1, '0, 0), 0);

    write_limit(32'd1000);
    drive_item(mk(KIND_READ, 200, '0, 0), 0);
    drive_item(mk(KIND_INSERT, 200, 32'd1000, 1), 0);
    drive_item(mk(KIND_INSERT, 200, 32'd999, 0), 0);
    drive_item(mk(KIND_READ, 200, '0, 0), 0);

    write_limit('1);
    random_phase(200, 1);
    write_limit('0);
    random_phase(200, 1);
    write_limit(32'h0001_0000);
    random_phase(200, 1);
    write_limit($urandom);
    random_phase(200, 1);
    write_limit(32'h0000_0080);
    random_phase(200, 1);
    write_limit('1);
    random_phase(200, 0);

    settle();
    if (sb.pending() != 0) sb.report("reads left without a result");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== polar_cell_min_depth_table_unit.f =====
rtl/pcmd_pkg.sv
rtl/pcmd_ram.sv
rtl/pcmd_update.sv
rtl/polar_cell_min_depth_table_unit.sv
dv/tb_polar_cell_min_depth_table_unit.sv
